// ----- sv/nrp_pkg.sv -----
// ============================================================================
// nrp_pkg - shared types and constants of the RMC position parser
// Character codes, field numbers, scaling constants and the tokens that
// travel from the byte parser through the scaling pipeline.
// ============================================================================
package nrp_pkg;

   // Number of fraction digits kept in a scaled position.
   localparam logic [2:0] FRAC_DIGITS = 3'd5;
   // Captured bytes after which an unfinished sentence is dropped.
   localparam logic [7:0] CAPTURE_LIMIT = 8'd50;

   localparam logic [2:0] HEADER_LAST = 3'd6;

   localparam logic [30:0] LAT_LIMIT = 31'd900000000;
   localparam logic [30:0] LON_LIMIT = 31'd1800000000;

   localparam int unsigned WORK_W = 32;
   localparam int unsigned SCALE_W = 20;
   localparam int unsigned PROD_W = WORK_W + SCALE_W;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_R      = 8'h52;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_C      = 8'h43;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_V      = 8'h56;
   localparam logic [7:0] CHAR_W      = 8'h57;

   localparam logic [2:0] FIELD_TIME   = 3'd0;
   localparam logic [2:0] FIELD_STATUS = 3'd1;
   localparam logic [2:0] FIELD_LAT    = 3'd2;
   localparam logic [2:0] FIELD_NS     = 3'd3;
   localparam logic [2:0] FIELD_LON    = 3'd4;
   localparam logic [2:0] FIELD_EW     = 3'd5;

   typedef struct packed {
      logic lat;    // finished latitude magnitude, stored for later
      logic emit;   // sentence ended, a result beat follows
      logic good;   // status was exactly A
      logic west;   // longitude hemisphere was W
      logic north;  // latitude hemisphere was exactly N
   } nrp_tag_type;

   typedef struct packed {
      logic              valid;
      nrp_tag_type       tag;
      logic [WORK_W-1:0] work;
      logic [2:0]        expo;
   } nrp_launch_type;

   typedef struct packed {
      logic        valid;
      nrp_tag_type tag;
      logic [30:0] mag;
   } nrp_scaled_type;

   function automatic logic [7:0] header_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0: b = CHAR_DOLLAR;
         3'd1: b = CHAR_G;
         3'd2: b = CHAR_P;
         3'd3: b = CHAR_R;
         3'd4: b = CHAR_M;
         3'd5: b = CHAR_C;
         3'd6: b = CHAR_COMMA;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [SCALE_W-1:0] pow10(input logic [2:0] e);
      logic [SCALE_W-1:0] p;
      case (e)
         3'd0: p = 20'd1;
         3'd1: p = 20'd10;
         3'd2: p = 20'd100;
         3'd3: p = 20'd1000;
         3'd4: p = 20'd10000;
         3'd5: p = 20'd100000;
         3'd6: p = 20'd1000000;
         default: p = 20'd0;
      endcase
      return p;
   endfunction

endpackage

// ----- sv/nrp_ifs.sv -----
// ============================================================================
// nrp_ifs - valid/ready channels of the RMC position parser
// One interface for the received byte stream, one for the position results.
// ============================================================================
interface nrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrp_rsp_if;
   logic               valid;
   logic               ready;
   logic               fix_valid;
   logic signed [30:0] latitude_value;
   logic signed [31:0] longitude_value;
   logic               ever_fixed;

   modport source (output valid, output fix_valid, output latitude_value,
                   output longitude_value, output ever_fixed, input ready);
   modport sink (input valid, input fix_valid, input latitude_value,
                 input longitude_value, input ever_fixed, output ready);
endinterface

// ----- sv/nrp_parser.sv -----
// ============================================================================
// nrp_parser - byte level sentence parser
// Hunts the header, splits fields, accumulates digits and launches the
// scaling of finished numbers and the end-of-sentence token.
// ============================================================================
module nrp_parser
   import nrp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     rx_byte,
   output nrp_launch_type launch
);

   logic [2:0]        header_pos_ff, header_pos_in;
   logic              capturing_ff, capturing_in;
   logic [2:0]        field_ff, field_in;
   logic              prev_comma_ff, prev_comma_in;
   logic              status_good_ff, status_good_in;
   logic              lat_north_ff, lat_north_in;
   logic [WORK_W-1:0] work_ff, work_in;
   logic              past_point_ff, past_point_in;
   logic [2:0]        seen_ff, seen_in;
   logic              ended_ff, ended_in;
   logic [7:0]        count_ff, count_in;

   logic              is_digit;
   logic [35:0]       times_ten;
   logic [7:0]        count_next;
   logic              first;
   logic              emitted;

   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign times_ten = ({4'd0, work_ff} << 3) + ({4'd0, work_ff} << 1)
                      + {32'd0, 4'(rx_byte - CHAR_ZERO)};
   assign count_next = count_ff + 8'd1;

   always_comb begin
      header_pos_in  = header_pos_ff;
      capturing_in   = capturing_ff;
      field_in       = field_ff;
      prev_comma_in  = prev_comma_ff;
      status_good_in = status_good_ff;
      lat_north_in   = lat_north_ff;
      work_in        = work_ff;
      past_point_in  = past_point_ff;
      seen_in        = seen_ff;
      ended_in       = ended_ff;
      count_in       = count_ff;
      first          = prev_comma_ff;
      emitted        = 1'b0;
      launch         = '0;
      launch.work    = work_ff;
      launch.expo    = FRAC_DIGITS - seen_ff;
      launch.tag.north = lat_north_ff;

      if (accept) begin
         if (!capturing_ff) begin
            if (rx_byte == header_byte(header_pos_ff)) begin
               if (header_pos_ff == HEADER_LAST) begin
                  header_pos_in  = 3'd0;
                  capturing_in   = 1'b1;
                  field_in       = FIELD_TIME;
                  prev_comma_in  = 1'b1;
                  status_good_in = 1'b0;
                  lat_north_in   = 1'b0;
                  count_in       = 8'd0;
                  work_in        = '0;
                  past_point_in  = 1'b0;
                  seen_in        = 3'd0;
                  ended_in       = 1'b0;
               end else begin
                  header_pos_in = header_pos_ff + 3'd1;
               end
            end else begin
               header_pos_in = 3'd0;
            end
         end else begin
            count_in = count_next;
            if (rx_byte == CHAR_V) begin
               emitted           = 1'b1;
               launch.valid      = 1'b1;
               launch.tag.emit   = 1'b1;
            end else if (rx_byte == CHAR_COMMA) begin
               if (!prev_comma_ff && (field_ff < FIELD_EW)) begin
                  if (field_ff == FIELD_LAT) begin
                     launch.valid   = 1'b1;
                     launch.tag.lat = 1'b1;
                  end
                  field_in = field_ff + 3'd1;
                  if ((field_in == FIELD_LAT) || (field_in == FIELD_LON)) begin
                     work_in       = '0;
                     past_point_in = 1'b0;
                     seen_in       = 3'd0;
                     ended_in      = 1'b0;
                  end
               end
               prev_comma_in = 1'b1;
            end else begin
               prev_comma_in = 1'b0;
               case (field_ff)
                  FIELD_STATUS: status_good_in = first && (rx_byte == CHAR_A);
                  FIELD_LAT, FIELD_LON: begin
                     if (!ended_ff) begin
                        if (is_digit) begin
                           if (!(past_point_ff && (seen_ff >= FRAC_DIGITS))) begin
                              if (past_point_ff) begin
                                 seen_in = seen_ff + 3'd1;
                              end
                              work_in = (times_ten[35:32] != 4'd0) ? '1 : times_ten[31:0];
                           end
                        end else if ((rx_byte == CHAR_POINT) && !past_point_ff) begin
                           past_point_in = 1'b1;
                        end else begin
                           ended_in = 1'b1;
                        end
                     end
                  end
                  FIELD_NS: lat_north_in = first && (rx_byte == CHAR_N);
                  FIELD_EW: begin
                     emitted         = 1'b1;
                     launch.valid    = 1'b1;
                     launch.tag.emit = 1'b1;
                     launch.tag.good = status_good_ff;
                     launch.tag.west = (rx_byte == CHAR_W);
                  end
                  default: ;
               endcase
            end
            if (emitted || (count_next >= CAPTURE_LIMIT)) begin
               capturing_in  = 1'b0;
               header_pos_in = 3'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pos_ff  <= 3'd0;
         capturing_ff   <= 1'b0;
         field_ff       <= FIELD_TIME;
         prev_comma_ff  <= 1'b0;
         status_good_ff <= 1'b0;
         lat_north_ff   <= 1'b0;
         work_ff        <= '0;
         past_point_ff  <= 1'b0;
         seen_ff        <= 3'd0;
         ended_ff       <= 1'b0;
         count_ff       <= 8'd0;
      end else begin
         header_pos_ff  <= header_pos_in;
         capturing_ff   <= capturing_in;
         field_ff       <= field_in;
         prev_comma_ff  <= prev_comma_in;
         status_good_ff <= status_good_in;
         lat_north_ff   <= lat_north_in;
         work_ff        <= work_in;
         past_point_ff  <= past_point_in;
         seen_ff        <= seen_in;
         ended_ff       <= ended_in;
         count_ff       <= count_in;
      end
   end

endmodule

// ----- sv/nrp_scale.sv -----
// ============================================================================
// nrp_scale - fixed point scaling pipeline
// Multiplies a finished digit accumulator by the missing power of ten and
// saturates it to the latitude or longitude limit, over three stages.
// ============================================================================
module nrp_scale
   import nrp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  nrp_launch_type launch,
   output nrp_scaled_type scaled
);

   logic              s1_valid_ff;
   nrp_tag_type       s1_tag_ff;
   logic [WORK_W-1:0] s1_work_ff;
   logic [2:0]        s1_expo_ff;

   logic              s2_valid_ff;
   nrp_tag_type       s2_tag_ff;
   logic [PROD_W-1:0] s2_prod_ff, s2_prod_in;

   logic              s3_valid_ff;
   nrp_tag_type       s3_tag_ff;
   logic [30:0]       s3_mag_ff, s3_mag_in;
   logic [30:0]       limit;

   assign s2_prod_in = PROD_W'(s1_work_ff) * PROD_W'(pow10(s1_expo_ff));

   assign limit = s2_tag_ff.lat ? LAT_LIMIT : LON_LIMIT;
   assign s3_mag_in = (s2_prod_ff > PROD_W'(limit)) ? limit : s2_prod_ff[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= launch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tag_ff  <= launch.tag;
         s1_work_ff <= launch.work;
         s1_expo_ff <= launch.expo;
         s2_tag_ff  <= s1_tag_ff;
         s2_prod_ff <= s2_prod_in;
         s3_tag_ff  <= s2_tag_ff;
         s3_mag_ff  <= s3_mag_in;
      end
   end

   assign scaled.valid = s3_valid_ff;
   assign scaled.tag   = s3_tag_ff;
   assign scaled.mag   = s3_mag_ff;

endmodule

// ----- sv/nrp_result.sv -----
// ============================================================================
// nrp_result - held positions and result register
// Stores the latitude magnitude, applies hemisphere signs, keeps the held
// positions and the sticky fix flag, and drives the result channel.
// ============================================================================
module nrp_result
   import nrp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  nrp_scaled_type scaled,
   output logic           advance,
   nrp_rsp_if.source      rsp_if
);

   logic [30:0]        lat_pending_ff;
   logic signed [30:0] lat_held_ff, lat_held_in;
   logic signed [31:0] lon_held_ff, lon_held_in;
   logic               fix_seen_ff, fix_seen_in;
   logic               rsp_valid_ff;
   logic               fix_valid_ff;
   logic signed [30:0] lat_out_ff;
   logic signed [31:0] lon_out_ff;
   logic               ever_out_ff;
   logic               take;
   logic               update;

   // The whole pipeline waits only while a result beat sits unread in front
   // of a new one.
   assign advance = !(scaled.valid && scaled.tag.emit && rsp_valid_ff && !rsp_if.ready);
   assign take    = advance && scaled.valid;
   assign update  = take && scaled.tag.emit && scaled.tag.good;

   always_comb begin
      lat_held_in = lat_held_ff;
      lon_held_in = lon_held_ff;
      fix_seen_in = fix_seen_ff;
      if (update) begin
         lat_held_in = scaled.tag.north ? lat_pending_ff : (31'd0 - lat_pending_ff);
         lon_held_in = scaled.tag.west ? (32'd0 - {1'b0, scaled.mag})
                                       : {1'b0, scaled.mag};
         fix_seen_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_held_ff  <= '0;
         lon_held_ff  <= '0;
         fix_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lat_held_ff <= lat_held_in;
         lon_held_ff <= lon_held_in;
         fix_seen_ff <= fix_seen_in;
         if (take && scaled.tag.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && scaled.tag.lat) begin
         lat_pending_ff <= scaled.mag;
      end
      if (take && scaled.tag.emit) begin
         fix_valid_ff <= scaled.tag.good;
         lat_out_ff   <= lat_held_in;
         lon_out_ff   <= lon_held_in;
         ever_out_ff  <= fix_seen_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.fix_valid       = fix_valid_ff;
   assign rsp_if.latitude_value  = lat_out_ff;
   assign rsp_if.longitude_value = lon_out_ff;
   assign rsp_if.ever_fixed      = ever_out_ff;

endmodule

// ----- sv/nmea_rmc_position_parser.sv -----
// ============================================================================
// nmea_rmc_position_parser - position extractor for RMC sentences
// Top level: byte parser, scaling pipeline and result register.
// ============================================================================
// The block takes one received byte per beat on the request channel and, for
// every RMC sentence that ends, returns one beat on the response channel with
// the fix flag, the held signed latitude and longitude (raw ddmm.mmmm scaled
// by ten to the number of kept fraction digits) and the sticky ever-fixed
// flag. A byte is taken in every cycle; the request side pauses only while a
// finished result reaches the result register and the previous result beat
// there has not yet been read. The beat that ends the sentence passes the
// three-stage scaling pipeline (input register, power-of-ten multiply,
// saturation) and then the result register (sign and hold update). A
// sentence that runs past the capture limit is dropped without a result and
// the header hunt resumes.
module nmea_rmc_position_parser
   import nrp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   nrp_req_if.sink   req_if,
   nrp_rsp_if.source rsp_if
);

   nrp_launch_type launch;
   nrp_scaled_type scaled;
   logic           advance;
   logic           accept;

   // A byte enters whenever the pipeline behind the parser can move.
   assign req_if.ready = advance;
   assign accept       = req_if.valid && advance;

   nrp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_if.rx_byte),
      .launch  (launch)
   );

   // The scaling pipeline runs in lock step with the parser and stalls with it.
   nrp_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .launch  (launch),
      .scaled  (scaled)
   );

   // Hemisphere signs, held positions and the result register.
   nrp_result u_result (
      .clock   (clock),
      .reset   (reset),
      .scaled  (scaled),
      .advance (advance),
      .rsp_if  (rsp_if)
   );

   // A reported fix always comes with the sticky flag set.
   a_fix_sets_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.fix_valid) |-> rsp_if.ever_fixed)
      else $error("fix reported without ever_fixed");

   // Saturation keeps the latitude within ninety degrees.
   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.latitude_value <= 31'sd900000000) &&
                        (rsp_if.latitude_value >= -31'sd900000000)))
      else $error("latitude out of range");

   // Saturation keeps the longitude within one hundred eighty degrees.
   a_lon_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.longitude_value <= 32'sd1800000000) &&
                        (rsp_if.longitude_value >= -32'sd1800000000)))
      else $error("longitude out of range");

   // A stalled result beat must never be overwritten by a new one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready && scaled.valid && scaled.tag.emit)
      |=> (rsp_if.valid && $stable(rsp_if.latitude_value)
           && $stable(rsp_if.longitude_value)))
      else $error("result beat overwritten while stalled");

endmodule
